// ===== hdl/tkd_pkg.sv =====
// ----------------------------------------------------------------------------
// tkd_pkg
// shared types and constants of the three-key debouncer with long press
// ----------------------------------------------------------------------------
package tkd_pkg;

    // timestamp width at the item port, and default width of the internal time base
    localparam int NOW_WIDTH      = 32;
    localparam int TIME_WIDTH_DEF = 32;

    // configuration registers
    localparam int CFG_WIDTH   = 16;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 4;

    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_COMBO      = 2'd2;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] COMBO_RST      = 16'd3000;

    // item operation
    typedef enum logic {
        OP_POLL = 1'b0,
        OP_SYNC = 1'b1
    } t_op;

    // event codes
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_A_SHORT = 3'd1,
        EV_A_LONG  = 3'd2,
        EV_B_SHORT = 3'd3,
        EV_B_LONG  = 3'd4,
        EV_C_SHORT = 3'd5,
        EV_C_LONG  = 3'd6,
        EV_COMBO   = 3'd7
    } t_key_event;

    // per-key flag state
    typedef struct packed {
        logic raw_prev;
        logic stable;
        logic long_done;
    } t_key_flags;

endpackage

// ===== hdl/tkd_if.sv =====
// ----------------------------------------------------------------------------
// tkd_if
// valid/ready channels: key poll beats in, event beats out
// ----------------------------------------------------------------------------
interface tkd_in_if
    import tkd_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [NOW_WIDTH-1:0] now_ms;
    logic                 key_a_pressed;
    logic                 key_b_pressed;
    logic                 key_c_pressed;

    modport source (
        output valid, operation, now_ms, key_a_pressed, key_b_pressed, key_c_pressed,
        input  ready
    );
    modport sink (
        input  valid, operation, now_ms, key_a_pressed, key_b_pressed, key_c_pressed,
        output ready
    );
endinterface

interface tkd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] key_event;

    modport source (
        output valid, key_event,
        input  ready
    );
    modport sink (
        input  valid, key_event,
        output ready
    );
endinterface

// ===== hdl/tkd_key.sv =====
// ----------------------------------------------------------------------------
// tkd_key
// one key's debounce, short and long press check for the current poll
// ----------------------------------------------------------------------------
module tkd_key
    import tkd_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                  i_en,
    input  logic                  i_level,
    input  t_key_flags            i_flags,
    input  logic [TIME_WIDTH-1:0] i_press_stamp,
    input  logic [TIME_WIDTH-1:0] i_now,
    input  logic                  i_db_pass,
    input  logic [CFG_WIDTH-1:0]  i_long_ms,
    output t_key_flags            o_flags,
    output logic [TIME_WIDTH-1:0] o_press_stamp,
    output logic                  o_short,
    output logic                  o_long
);

    logic [TIME_WIDTH-1:0] w_held;
    logic                  w_held_long;

    // wraps modulo 2^TIME_WIDTH
    assign w_held      = i_now - i_press_stamp;
    assign w_held_long = w_held > TIME_WIDTH'(i_long_ms);

    always_comb begin
        o_flags       = i_flags;
        o_press_stamp = i_press_stamp;
        o_short       = 1'b0;
        o_long        = 1'b0;
        if (i_en) begin
            o_flags.raw_prev = i_level;
            if (i_db_pass) begin
                if (i_level != i_flags.stable) begin
                    o_flags.stable = i_level;
                    if (i_level) begin
                        o_press_stamp     = i_now;
                        o_flags.long_done = 1'b0;
                    end else if (!i_flags.long_done) begin
                        o_short = 1'b1;
                    end
                end else if (i_flags.stable && !i_flags.long_done && w_held_long) begin
                    // a fresh press has zero hold time, so only a steady press can go long
                    o_flags.long_done = 1'b1;
                    o_long            = 1'b1;
                end
            end
        end
    end

endmodule

// ===== hdl/three_key_debounce_long_press.sv =====
// ----------------------------------------------------------------------------
// three_key_debounce_long_press
// debouncer for three active-high key inputs with short, long and A+C combo events
// ----------------------------------------------------------------------------
// a poll beat is held in the input register, then its event beat in the output register
// throughput: one poll or sync beat per cycle, set by the state update, while the output is not stalled
// the input register, when empty, takes a new beat while an event waits in the output register
// reset (i_rst_n low, synchronous): thresholds 50 / 1000 / 3000 ms, all keys seen
// as pressed, stamps zero, combo timer stopped, both registers empty
// ----------------------------------------------------------------------------
module three_key_debounce_long_press
    import tkd_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tkd_in_if.sink                i_poll,
    tkd_out_if.source             o_event,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int NOW_EXT = (TIME_WIDTH > NOW_WIDTH) ? TIME_WIDTH : NOW_WIDTH;
    localparam int NKEYS   = 3;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [CFG_WIDTH-1:0] r_debounce_ms;
    logic [CFG_WIDTH-1:0] r_long_ms;
    logic [CFG_WIDTH-1:0] r_combo_ms;
    logic                 w_cfg_wr;
    logic [1:0]           w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEBOUNCE_RST;
            r_long_ms     <= LONG_PRESS_RST;
            r_combo_ms    <= COMBO_RST;
        end else if (w_cfg_wr) begin
            // writes beyond the last register fall through unused
            unique case (w_cfg_idx)
                REG_DEBOUNCE:   r_debounce_ms <= pwdata[CFG_WIDTH-1:0];
                REG_LONG_PRESS: r_long_ms     <= pwdata[CFG_WIDTH-1:0];
                REG_COMBO:      r_combo_ms    <= pwdata[CFG_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_DEBOUNCE:   prdata = APB_DATA_W'(r_debounce_ms);
            REG_LONG_PRESS: prdata = APB_DATA_W'(r_long_ms);
            REG_COMBO:      prdata = APB_DATA_W'(r_combo_ms);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // input register and handshake
    // ------------------------------------------------------------------------
    logic                 r_in_valid;
    t_op                  r_in_op;
    logic [NOW_WIDTH-1:0] r_in_now;
    logic [NKEYS-1:0]     r_in_keys;
    logic                 r_out_valid;
    t_key_event           r_out_event;
    logic                 w_advance;
    logic                 w_in_beat;

    // the registered beat moves on when the output register is free or draining
    assign w_advance    = r_in_valid && (!r_out_valid || o_event.ready);
    assign i_poll.ready = !r_in_valid || w_advance;
    assign w_in_beat    = i_poll.valid && i_poll.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_beat) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_in_op   <= t_op'(i_poll.operation);
            r_in_now  <= i_poll.now_ms;
            r_in_keys <= {i_poll.key_c_pressed, i_poll.key_b_pressed, i_poll.key_a_pressed};
        end
    end

    // ------------------------------------------------------------------------
    // key state
    // ------------------------------------------------------------------------
    logic [TIME_WIDTH-1:0] r_db_stamp;
    t_key_flags            r_flags       [NKEYS];
    logic [TIME_WIDTH-1:0] r_press_stamp [NKEYS];
    logic [TIME_WIDTH-1:0] r_combo_stamp;
    logic                  r_combo_running;

    logic [NOW_EXT-1:0]    w_now_ext;
    logic [TIME_WIDTH-1:0] w_now;
    logic                  w_poll;

    // timestamp taken modulo 2^TIME_WIDTH
    assign w_now_ext = NOW_EXT'(r_in_now);
    assign w_now     = w_now_ext[TIME_WIDTH-1:0];
    assign w_poll    = (r_in_op == OP_POLL);

    // ------------------------------------------------------------------------
    // A+C combo timer, checked ahead of the keys
    // ------------------------------------------------------------------------
    logic                  w_both;
    logic [TIME_WIDTH-1:0] w_combo_held;
    logic                  w_combo_fire;
    logic                  n_combo_running;
    logic [TIME_WIDTH-1:0] n_combo_stamp;

    assign w_both       = r_in_keys[0] && r_in_keys[2];
    assign w_combo_held = w_now - r_combo_stamp;
    // a timer that starts in this poll has zero hold time and cannot fire
    assign w_combo_fire = w_poll && w_both && r_combo_running &&
                          (w_combo_held > TIME_WIDTH'(r_combo_ms));

    always_comb begin
        n_combo_running = r_combo_running;
        n_combo_stamp   = r_combo_stamp;
        if (w_poll) begin
            if (!w_both) begin
                n_combo_running = 1'b0;
            end else if (!r_combo_running) begin
                n_combo_running = 1'b1;
                n_combo_stamp   = w_now;
            end else if (w_combo_fire) begin
                n_combo_running = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // keys A, B, C in order; the first event stops the scan
    // ------------------------------------------------------------------------
    logic [TIME_WIDTH-1:0] w_db_held;
    logic                  w_db_elapsed;
    logic [NKEYS-1:0]      w_en;
    logic [NKEYS-1:0]      w_chg;
    logic [NKEYS-1:0]      w_db_pass;
    logic [NKEYS-1:0]      w_short;
    logic [NKEYS-1:0]      w_long;
    t_key_flags            w_flags       [NKEYS];
    logic [TIME_WIDTH-1:0] w_press_stamp [NKEYS];

    // a raw change on any key scanned so far restarts the shared stamp, which
    // leaves zero elapsed time and so blocks the debounce for the rest of the scan
    assign w_db_held    = w_now - r_db_stamp;
    assign w_db_elapsed = w_db_held > TIME_WIDTH'(r_debounce_ms);

    assign w_en[0] = w_poll && !w_combo_fire;
    assign w_en[1] = w_en[0] && !(w_short[0] || w_long[0]);
    assign w_en[2] = w_en[1] && !(w_short[1] || w_long[1]);

    assign w_db_pass[0] = w_db_elapsed && !w_chg[0];
    assign w_db_pass[1] = w_db_elapsed && !(|w_chg[1:0]);
    assign w_db_pass[2] = w_db_elapsed && !(|w_chg[2:0]);

    for (genvar k = 0; k < NKEYS; k++) begin : g_key
        assign w_chg[k] = w_en[k] && (r_in_keys[k] != r_flags[k].raw_prev);

        tkd_key #(
            .TIME_WIDTH (TIME_WIDTH)
        ) u_key (
            .i_en          (w_en[k]),
            .i_level       (r_in_keys[k]),
            .i_flags       (r_flags[k]),
            .i_press_stamp (r_press_stamp[k]),
            .i_now         (w_now),
            .i_db_pass     (w_db_pass[k]),
            .i_long_ms     (r_long_ms),
            .o_flags       (w_flags[k]),
            .o_press_stamp (w_press_stamp[k]),
            .o_short       (w_short[k]),
            .o_long        (w_long[k])
        );
    end

    // ------------------------------------------------------------------------
    // event select
    // ------------------------------------------------------------------------
    t_key_event            n_event;
    logic [TIME_WIDTH-1:0] n_db_stamp;

    always_comb begin
        priority if (!w_poll)      n_event = EV_NONE;
        else if (w_combo_fire)     n_event = EV_COMBO;
        else if (w_short[0])       n_event = EV_A_SHORT;
        else if (w_long[0])        n_event = EV_A_LONG;
        else if (w_short[1])       n_event = EV_B_SHORT;
        else if (w_long[1])        n_event = EV_B_LONG;
        else if (w_short[2])       n_event = EV_C_SHORT;
        else if (w_long[2])        n_event = EV_C_LONG;
        else                       n_event = EV_NONE;
    end

    // a sync restarts the stamp as well
    assign n_db_stamp = (!w_poll || (|w_chg)) ? w_now : r_db_stamp;

    // ------------------------------------------------------------------------
    // state update, one beat per cycle while the output register is free or draining
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_db_stamp      <= '0;
            r_combo_stamp   <= '0;
            r_combo_running <= 1'b0;
            for (int k = 0; k < NKEYS; k++) begin
                r_flags[k]       <= '{raw_prev: 1'b1, stable: 1'b1, long_done: 1'b0};
                r_press_stamp[k] <= '0;
            end
        end else if (w_advance) begin
            r_db_stamp      <= n_db_stamp;
            r_combo_stamp   <= n_combo_stamp;
            r_combo_running <= n_combo_running;
            for (int k = 0; k < NKEYS; k++) begin
                if (w_poll) begin
                    r_flags[k]       <= w_flags[k];
                    r_press_stamp[k] <= w_press_stamp[k];
                end else begin
                    // sync adopts the levels as stable and clears press history
                    r_flags[k]       <= '{raw_prev: r_in_keys[k], stable: r_in_keys[k],
                                          long_done: 1'b0};
                    r_press_stamp[k] <= '0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_event.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_event <= n_event;
        end
    end

    assign o_event.valid     = r_out_valid;
    assign o_event.key_event = r_out_event;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_poll.ready)
        else $error("input stalled with the output register empty");

    a_combo_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && w_combo_fire |=> !r_combo_running && o_event.key_event == EV_COMBO)
        else $error("combo event did not stop the combo timer");

    a_sync_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && !w_poll |=> !r_flags[0].long_done && !r_flags[1].long_done &&
                                 !r_flags[2].long_done && o_event.key_event == EV_NONE)
        else $error("sync left a long flag or produced an event");

    a_one_key_fires: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> $countones({w_short, w_long}) <= 1)
        else $error("more than one key produced an event in one poll");

endmodule

// ===== test/three_key_debounce_long_press_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_key_debounce_long_press_test
// self-checking bench for the three-key debouncer: key polls and syncs go in,
// one event code per beat comes out and is compared with a local model of the
// debounce, long press and a+c combo logic, over several threshold settings
// ----------------------------------------------------------------------------
module three_key_debounce_long_press_test;
    import tkd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AFTER  = 150;   // poll beats accepted before the long sink hold-off
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_ITEMS = 72;

    // index past the last threshold register, writes there must be dropped
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam logic [1:0] REG_MAP [3] = '{REG_DEBOUNCE, REG_LONG_PRESS, REG_COMBO};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tkd_in_if  poll_if ();
    tkd_out_if event_if ();

    three_key_debounce_long_press u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_poll  (poll_if),
        .o_event (event_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------
    // local model of the key logic
    // ------------------------------------------------------------------------
    logic [CFG_WIDTH-1:0] settle_ms;
    logic [CFG_WIDTH-1:0] hold_ms;
    logic [CFG_WIDTH-1:0] combo_hold_ms;

    logic [31:0] bounce_mark;       // shared by all three keys
    logic [2:0]  last_raw;
    logic [2:0]  settled;
    logic [2:0]  long_fired;
    logic [31:0] held_since [3];
    logic [31:0] combo_since;
    logic        combo_armed;

    // one key: debounce, then short on release or long while held
    function automatic t_key_event judge_key(input int k, input logic r,
                                             input logic [31:0] now,
                                             input t_key_event ev_short,
                                             input t_key_event ev_long);
        t_key_event ev;
        logic [31:0] gap;
        ev = EV_NONE;
        if (r != last_raw[k]) begin
            bounce_mark = now;
        end
        gap = now - bounce_mark;
        if (gap > 32'(settle_ms)) begin
            if (r != settled[k]) begin
                settled[k] = r;
                if (r) begin
                    held_since[k] = now;
                    long_fired[k] = 1'b0;
                end else if (!long_fired[k]) begin
                    ev = ev_short;
                end
            end
            gap = now - held_since[k];
            if (ev == EV_NONE && settled[k] && !long_fired[k] && gap > 32'(hold_ms)) begin
                long_fired[k] = 1'b1;
                ev = ev_long;
            end
        end
        last_raw[k] = r;
        return ev;
    endfunction

    // lv: bit 0 key a, bit 1 key b, bit 2 key c
    function automatic t_key_event step_keys(input t_op op, input logic [31:0] now,
                                             input logic [2:0] lv);
        t_key_event ev;
        logic [31:0] gap;
        if (op == OP_SYNC) begin
            last_raw    = lv;
            settled     = lv;
            long_fired  = 3'b000;
            bounce_mark = now;
            for (int k = 0; k < 3; k++) begin
                held_since[k] = '0;
            end
            return EV_NONE;
        end
        if (lv[0] && lv[2]) begin
            if (!combo_armed) begin
                combo_armed = 1'b1;
                combo_since = now;
            end
            gap = now - combo_since;
            if (gap > 32'(combo_hold_ms)) begin
                combo_armed = 1'b0;
                return EV_COMBO;
            end
        end else begin
            combo_armed = 1'b0;
        end
        // the first key with an event ends the poll, later keys are not looked at
        ev = judge_key(0, lv[0], now, EV_A_SHORT, EV_A_LONG);
        if (ev == EV_NONE) begin
            ev = judge_key(1, lv[1], now, EV_B_SHORT, EV_B_LONG);
        end
        if (ev == EV_NONE) begin
            ev = judge_key(2, lv[2], now, EV_C_SHORT, EV_C_LONG);
        end
        return ev;
    endfunction

    // ------------------------------------------------------------------------
    // directed polls, keys written as {c, b, a}; an event is typed in where
    // it is plain from the thresholds, otherwise the model decides
    // ------------------------------------------------------------------------
    typedef struct packed {
        t_op        op;
        logic [31:0] now;
        logic [2:0]  keys;
        logic        pinned;
        t_key_event  ev;
    } t_poll_row;

    t_poll_row directed_rows [25] = '{
        '{OP_POLL, 32'd10,   3'b111, 1'b1, EV_NONE},     // all held from reset, too early
        '{OP_POLL, 32'd1000, 3'b111, 1'b1, EV_NONE},     // hold exactly at the long threshold
        '{OP_POLL, 32'd1001, 3'b111, 1'b1, EV_A_LONG},
        '{OP_POLL, 32'd1002, 3'b111, 1'b1, EV_B_LONG},
        '{OP_POLL, 32'd1003, 3'b111, 1'b1, EV_C_LONG},
        '{OP_POLL, 32'd3010, 3'b111, 1'b1, EV_NONE},     // combo exactly at threshold
        '{OP_POLL, 32'd3011, 3'b111, 1'b1, EV_COMBO},
        '{OP_POLL, 32'd3020, 3'b110, 1'b1, EV_NONE},     // a lets go, combo stops
        '{OP_POLL, 32'd3071, 3'b110, 1'b1, EV_NONE},     // release after a long press
        '{OP_SYNC, 32'd4000, 3'b000, 1'b1, EV_NONE},
        '{OP_POLL, 32'd4100, 3'b010, 1'b1, EV_NONE},
        '{OP_POLL, 32'd4150, 3'b010, 1'b1, EV_NONE},     // debounce exactly at threshold
        '{OP_POLL, 32'd4151, 3'b010, 1'b1, EV_NONE},     // b now stably pressed
        '{OP_POLL, 32'd4300, 3'b000, 1'b1, EV_NONE},
        '{OP_POLL, 32'd4351, 3'b000, 1'b1, EV_B_SHORT},
        '{OP_POLL, 32'd5000, 3'b001, 1'b0, EV_NONE},
        '{OP_POLL, 32'd5100, 3'b001, 1'b0, EV_NONE},
        '{OP_POLL, 32'd5200, 3'b000, 1'b0, EV_NONE},
        '{OP_POLL, 32'd5300, 3'b100, 1'b0, EV_NONE},     // a short hides the c edge
        '{OP_POLL, 32'd5301, 3'b100, 1'b0, EV_NONE},
        '{OP_POLL, 32'd5352, 3'b100, 1'b0, EV_NONE},
        '{OP_POLL, 32'd6353, 3'b100, 1'b0, EV_NONE},
        '{OP_SYNC, 32'hFFFF_FFF0, 3'b100, 1'b1, EV_NONE},
        '{OP_POLL, 32'h0000_0023, 3'b100, 1'b0, EV_NONE}, // across the timestamp wrap
        '{OP_POLL, 32'hFFFF_FFFF, 3'b111, 1'b0, EV_NONE}
    };

    typedef struct packed {
        logic       pinned;
        t_key_event ev;
    } t_pin;

    t_pin       typed_events [$];   // one per offered beat, in order
    t_key_event due_events [$];     // events still to come out

    int fault_count;
    int in_beats;
    int cycle_count;
    int events_seen [8];
    int settings_run;

    bit          sender_idle;
    bit          sink_idle;
    logic [31:0] clock_ms;
    logic [2:0]  held_keys;

    // ------------------------------------------------------------------------
    // clock, cycle limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("three_key_debounce_long_press_test: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // event sink: random stalls, plus one long hold-off once traffic is going
    // so that both registers fill and the poll side backs up
    // ------------------------------------------------------------------------
    initial begin : sink_side
        int stall_left;
        int hold_left;
        bit held_once;
        stall_left = 0;
        hold_left  = 0;
        held_once  = 1'b0;
        event_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held_once && in_beats >= HOLD_AFTER) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                event_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                event_if.ready <= 1'b0;
            end else if (sink_idle && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 3);
                event_if.ready <= 1'b0;
            end else begin
                event_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: values seen here are the ones from before the edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_key_event want;
        t_key_event guess;
        t_pin       pin;
        if (i_rst_n) begin
            // output first: an event never belongs to a poll taken at the same edge
            if (event_if.valid && event_if.ready) begin
                if (due_events.size() == 0) begin
                    $error("key_event: expected nothing, actual %0d", event_if.key_event);
                    fault_count++;
                end else begin
                    want = due_events.pop_front();
                    events_seen[want]++;
                    if (event_if.key_event !== want) begin
                        $error("key_event: expected %0d (%s), actual %0d",
                               want, want.name(), event_if.key_event);
                        fault_count++;
                    end
                end
            end
            if (poll_if.valid && poll_if.ready) begin
                guess = step_keys(t_op'(poll_if.operation), poll_if.now_ms,
                                  {poll_if.key_c_pressed, poll_if.key_b_pressed,
                                   poll_if.key_a_pressed});
                pin = typed_events.pop_front();
                due_events.push_back(pin.pinned ? pin.ev : guess);
                in_beats++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // poll source and register port
    // ------------------------------------------------------------------------
    task automatic send_poll(input t_op op, input logic [31:0] now, input logic [2:0] lv,
                             input logic pinned, input t_key_event ev);
        t_pin pin;
        pin.pinned = pinned;
        pin.ev     = ev;
        if (sender_idle && $urandom_range(0, 3) == 0) begin
            poll_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        typed_events.push_back(pin);
        poll_if.valid         <= 1'b1;
        poll_if.operation     <= op;
        poll_if.now_ms        <= now;
        poll_if.key_a_pressed <= lv[0];
        poll_if.key_b_pressed <= lv[1];
        poll_if.key_c_pressed <= lv[2];
        do @(posedge i_clk); while (!poll_if.ready);
    endtask

    // stop offering and wait until every expected event is out, first letting the monitor
    // count the beat taken at the last edge as due
    task automatic drain_events();
        poll_if.valid <= 1'b0;
        @(posedge i_clk);
        while (due_events.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic apb_cycle(input logic wr, input logic [1:0] idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_thresholds(input logic [15:0] s, input logic [15:0] h,
                                    input logic [15:0] c);
        logic [31:0] rd;
        logic [15:0] want [3];
        want = '{s, h, c};
        for (int k = 0; k < 3; k++) begin
            apb_cycle(1'b0, REG_MAP[k], 32'h0, rd);
            if (rd !== {16'h0, want[k]}) begin
                $error("prdata reg %0d: expected %0d, actual %0d", k, want[k], rd);
                fault_count++;
            end
        end
    endtask

    // upper data bits are noise, the spare index must not disturb anything
    task automatic set_thresholds(input logic [15:0] s, input logic [15:0] h,
                                  input logic [15:0] c);
        logic [31:0] rd;
        apb_cycle(1'b1, REG_DEBOUNCE,   {16'($urandom), s}, rd);
        apb_cycle(1'b1, REG_LONG_PRESS, {16'($urandom), h}, rd);
        apb_cycle(1'b1, REG_COMBO,      {16'($urandom), c}, rd);
        apb_cycle(1'b1, REG_SPARE,      $urandom, rd);
        settle_ms     = s;
        hold_ms       = h;
        combo_hold_ms = c;
        check_thresholds(s, h, c);
        settings_run++;
    endtask

    // random polls: time steps sized to the thresholds, keys held for a while
    // with the odd bounce, some noise and an occasional sync
    task automatic run_phase(input int n_items, input bit idle_on, input bit pause_mid);
        t_op         op;
        logic [2:0]  lv;
        logic [31:0] gap;
        logic [31:0] span;
        int          k;
        span = 32'(settle_ms);
        if (32'(hold_ms) > span) span = 32'(hold_ms);
        if (32'(combo_hold_ms) > span) span = 32'(combo_hold_ms);
        span = span / 6 + 2;
        for (int i = 0; i < n_items; i++) begin
            sender_idle = idle_on && ((i / 20) % 3 != 2);
            sink_idle   = idle_on && ((i / 20) % 3 != 1);
            if (pause_mid && i == n_items / 2) begin
                drain_events();
            end
            case ($urandom_range(0, 9))
                0: gap = 32'd0;
                1: gap = 32'd1;
                6: gap = 32'(settle_ms) + $urandom_range(0, 2);
                7: gap = 32'(hold_ms) / 2 + $urandom_range(0, 2);
                8: gap = $urandom_range(0, 8);
                9: gap = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, span);
                default: gap = $urandom_range(0, span);
            endcase
            clock_ms = clock_ms + gap;
            if ($urandom_range(0, 4) == 0) begin
                k = $urandom_range(0, 2);
                held_keys[k] = ~held_keys[k];
            end
            lv = held_keys;
            if ($urandom_range(0, 7) == 0) begin
                k = $urandom_range(0, 2);
                lv[k] = ~lv[k];
            end
            if ($urandom_range(0, 15) == 0) begin
                lv = 3'($urandom);
            end
            op = ($urandom_range(0, 39) == 0) ? OP_SYNC : OP_POLL;
            send_poll(op, clock_ms, lv, 1'b0, EV_NONE);
        end
        poll_if.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int shorts;
        int longs;

        // everything the block sees is known from time zero
        i_rst_n               <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        poll_if.valid         <= 1'b0;
        poll_if.operation     <= OP_POLL;
        poll_if.now_ms        <= '0;
        poll_if.key_a_pressed <= 1'b0;
        poll_if.key_b_pressed <= 1'b0;
        poll_if.key_c_pressed <= 1'b0;

        // model state after reset: all keys seen as pressed, stamps at zero
        settle_ms     = DEBOUNCE_RST;
        hold_ms       = LONG_PRESS_RST;
        combo_hold_ms = COMBO_RST;
        bounce_mark   = '0;
        last_raw      = 3'b111;
        settled       = 3'b111;
        long_fired    = 3'b000;
        combo_since   = '0;
        combo_armed   = 1'b0;
        for (int k = 0; k < 3; k++) begin
            held_since[k] = '0;
        end
        sender_idle = 1'b1;
        sink_idle   = 1'b1;
        held_keys   = 3'b000;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        check_thresholds(DEBOUNCE_RST, LONG_PRESS_RST, COMBO_RST);

        foreach (directed_rows[r]) begin
            send_poll(directed_rows[r].op, directed_rows[r].now, directed_rows[r].keys,
                      directed_rows[r].pinned, directed_rows[r].ev);
        end
        clock_ms = 32'd100000;

        // reset thresholds first, then zeros, all ones, random and mixed ones
        run_phase(PHASE_ITEMS, 1'b1, 1'b0);
        drain_events();
        set_thresholds(16'd0, 16'd0, 16'd0);
        run_phase(PHASE_ITEMS, 1'b1, 1'b1);
        drain_events();
        set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(PHASE_ITEMS, 1'b1, 1'b0);
        drain_events();
        set_thresholds(16'($urandom_range(0, 100)), 16'($urandom_range(0, 2000)),
                       16'($urandom_range(0, 4000)));
        run_phase(PHASE_ITEMS, 1'b1, 1'b0);
        drain_events();
        set_thresholds(16'd1, 16'hFFFF, 16'd0);
        run_phase(PHASE_ITEMS, 1'b1, 1'b0);
        drain_events();
        // last stretch runs flat out on both sides
        set_thresholds(16'($urandom_range(0, 20)), 16'($urandom_range(0, 200)),
                       16'($urandom_range(0, 300)));
        run_phase(PHASE_ITEMS, 1'b0, 1'b0);

        drain_events();
        repeat (4) @(posedge i_clk);

        shorts = events_seen[EV_A_SHORT] + events_seen[EV_B_SHORT] + events_seen[EV_C_SHORT];
        longs  = events_seen[EV_A_LONG] + events_seen[EV_B_LONG] + events_seen[EV_C_LONG];
        $display("%0d key beats checked under reset thresholds and %0d written settings",
                 in_beats, settings_run);
        $display("events: %0d quiet, %0d short, %0d long, %0d combo",
                 events_seen[EV_NONE], shorts, longs, events_seen[EV_COMBO]);
        if (fault_count == 0) begin
            $display("three_key_debounce_long_press_test: done, clean");
        end else begin
            $display("three_key_debounce_long_press_test: done, errors");
        end
        $finish;
    end

endmodule
